@@ rtl/dpca_pkg.sv @@
// Shared types and constants of the DMA pool carve and bump allocator.
package dpca_pkg;

    localparam int MAP_ENTRIES_DEF    = 32;
    localparam int MODULE_ENTRIES_DEF = 16;
    localparam int Q_DEPTH            = 2;

    localparam logic [31:0] MIN_DMA   = 32'h0010_0000;
    localparam logic [32:0] PAGE_M1   = 33'h0_0000_0FFF;
    localparam logic [63:0] TOP32     = 64'h0000_0000_FFFF_FFFF;
    localparam logic [31:0] TOP_PAGE  = 32'hFFFF_F000;

    localparam logic [2:0] KIND_USABLE   = 3'd0;
    localparam logic [2:0] KIND_RESERVED = 3'd1;
    localparam logic [2:0] KIND_KERNEL   = 3'd2;
    localparam logic [2:0] KIND_META     = 3'd3;
    localparam logic [2:0] KIND_MODULE   = 3'd4;

    typedef enum logic [1:0] {
        OP_BEGIN   = 2'd0,
        OP_LOAD    = 2'd1,
        OP_BUILD   = 2'd2,
        OP_RESERVE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_REFUSED = 2'd1,
        ST_INVALID = 2'd2,
        ST_NO_GAP  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RES_ALIGN,
        S_RES_CHECK,
        S_U_RD,
        S_U_INIT,
        S_WALK,
        S_EX,
        S_STEP
    } t_state;

    typedef struct packed {
        t_op         op;
        logic [2:0]  kind;
        logic [63:0] base;
        logic [63:0] length;
        logic [31:0] size;
        logic [31:0] align;
        logic        wrap;
        logic        fits;
        logic        len_zero;
        logic        res_ok;
    } t_item;

    typedef struct packed {
        logic [31:0] cursor;
        logic [31:0] pool_end;
    } t_back_stat;

endpackage

@@ rtl/dpca_front.sv @@
// Front end: accepts request transfers and classifies them into queue items.
module dpca_front (
    input  logic                  i_tvalid,
    output logic                  o_tready,
    input  logic [191:0]          i_tdata,
    input  logic [4:0]            i_tuser,
    input  logic                  i_q_full,
    output logic                  o_push,
    output dpca_pkg::t_item       o_item
);
    import dpca_pkg::*;

    logic [64:0] sum;
    logic [31:0] al;

    assign al  = i_tdata[191:160];
    assign sum = {1'b0, i_tdata[63:0]} + {1'b0, i_tdata[127:64]};

    assign o_tready = !i_q_full;
    assign o_push   = i_tvalid && !i_q_full;

    always_comb begin
        o_item.op       = t_op'(i_tuser[1:0]);
        o_item.kind     = i_tuser[4:2];
        o_item.base     = i_tdata[63:0];
        o_item.length   = i_tdata[127:64];
        o_item.size     = i_tdata[159:128];
        o_item.align    = al;
        // A range wraps when base plus length carries out of 64 bits.
        o_item.wrap     = sum[64];
        // The span fits the 32-bit space when its end is at most 4 GiB.
        o_item.fits     = (i_tdata[63:32] == 32'd0) && (sum <= 65'h1_0000_0000);
        o_item.len_zero = (i_tdata[127:64] == 64'd0);
        o_item.res_ok   = (i_tdata[159:128] != 32'd0) && (al != 32'd0) &&
                          ((al & (al - 32'd1)) == 32'd0);
    end
endmodule

@@ rtl/dpca_queue.sv @@
// Short queue that decouples the front end from the back end.
module dpca_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  dpca_pkg::t_item  i_item,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output dpca_pkg::t_item  o_item
);
    import dpca_pkg::*;

    localparam int QAW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QCW = $clog2(Q_DEPTH + 1);

    t_item            r_mem [Q_DEPTH];
    logic [QAW-1:0]   r_wp, r_rp;
    logic [QCW-1:0]   r_cnt;

    function automatic logic [QAW-1:0] bump(input logic [QAW-1:0] p);
        return (p == QAW'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full  = (r_cnt == QCW'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= bump(r_wp);
            if (i_pop)  r_rp <= bump(r_rp);
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_item;
    end
endmodule

@@ rtl/dpca_back.sv @@
// Back end: range tables, pool build scan and bump reservation.
module dpca_back #(
    parameter int MAP_ENTRIES    = dpca_pkg::MAP_ENTRIES_DEF,
    parameter int MODULE_ENTRIES = dpca_pkg::MODULE_ENTRIES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    input  dpca_pkg::t_item       i_q_item,
    output logic                  o_q_pop,
    output logic                  o_tvalid,
    input  logic                  i_tready,
    output logic [95:0]           o_tdata,
    output logic [1:0]            o_tuser,
    output dpca_pkg::t_back_stat  o_stat
);
    import dpca_pkg::*;

    localparam int EXCL = MAP_ENTRIES + MODULE_ENTRIES + 2;
    localparam int UCW  = $clog2(MAP_ENTRIES + 1);
    localparam int UIW  = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
    localparam int ECW  = $clog2(EXCL + 1);
    localparam int EIW  = $clog2(EXCL);
    localparam int MCW  = $clog2(MODULE_ENTRIES + 2);
    localparam logic [UCW-1:0] MAP_FULL  = UCW'(MAP_ENTRIES);
    localparam logic [ECW-1:0] EXCL_FULL = ECW'(EXCL);
    localparam logic [MCW-1:0] MOD_FULL  = MCW'(MODULE_ENTRIES);

    t_state r_state, n_state;

    logic [127:0] u_mem [MAP_ENTRIES];
    logic [127:0] e_mem [EXCL];
    logic [127:0] r_u_rd, r_e_rd;
    logic         u_we, e_we;

    logic [UCW-1:0] r_ucnt, n_ucnt, r_mcnt, n_mcnt, r_i, n_i;
    logic [ECW-1:0] r_ecnt, n_ecnt, r_j, n_j;
    logic [MCW-1:0] r_modcnt, n_modcnt;
    logic r_kseen, n_kseen, r_mseen, n_mseen, r_inval, n_inval;
    logic r_rdv, n_rdv, r_out_valid, n_out_valid;
    logic [31:0] r_cursor, n_cursor, r_end, n_end;

    t_item       r_item, n_item;
    logic [32:0] r_cur, n_cur, r_largest, n_largest, r_a, n_a;
    logic [31:0] r_wend, n_wend, r_next, n_next;
    logic [63:0] r_cov, n_cov;
    t_status     r_st, n_st;
    logic [31:0] r_addr, n_addr, r_gr, n_gr;

    // Condition terms used by the next-state and datapath blocks.
    logic        idle_go, build_ok, res_pre_ok, walk_more, u_more, ex_done;
    logic [63:0] ub, ul, usum, eb, el, ee, cur64;
    logic [31:0] bb, endc;
    logic [32:0] ini_cur, up_cov, gap, gap_len, a_calc, al33;
    logic        u_skip, better, res_bad;

    assign idle_go    = (r_state == S_IDLE) && i_q_valid && !r_out_valid;
    assign build_ok   = !r_inval && (r_mcnt != '0) && r_kseen && r_mseen &&
                        (r_ucnt != '0);
    assign res_pre_ok = i_q_item.res_ok && (r_cursor != 32'd0);
    assign walk_more  = r_cur < {1'b0, r_wend};
    assign u_more     = (r_i + 1'b1) < r_ucnt;
    assign ex_done    = (r_j == r_ecnt) && !r_rdv;

    assign ub      = r_u_rd[63:0];
    assign ul      = r_u_rd[127:64];
    assign usum    = ub + ul;
    assign u_skip  = (ub[63:32] != 32'd0);
    assign bb      = (ub[31:0] < MIN_DMA) ? MIN_DMA : ub[31:0];
    assign ini_cur = ({1'b0, bb} + PAGE_M1) & ~PAGE_M1;
    assign endc    = (usum > TOP32) ? TOP_PAGE : {usum[31:12], 12'h000};

    assign eb    = r_e_rd[63:0];
    assign el    = r_e_rd[127:64];
    assign ee    = eb + el;
    assign cur64 = {31'd0, r_cur};

    assign up_cov  = ({1'b0, r_cov[31:0]} + PAGE_M1) & ~PAGE_M1;
    assign gap     = {1'b0, r_next[31:12], 12'h000};
    assign gap_len = gap - r_cur;
    assign better  = (gap > r_cur) && (gap_len > r_largest);

    assign al33    = {1'b0, r_item.align} - 33'd1;
    assign a_calc  = ({1'b0, r_cursor} + al33) & ~al33;
    assign res_bad = (r_a > {1'b0, r_end}) ||
                     ({1'b0, r_item.size} > ({1'b0, r_end} - r_a));

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (idle_go) begin
                    case (i_q_item.op)
                        OP_BUILD:   n_state = build_ok ? S_U_RD : S_IDLE;
                        OP_RESERVE: n_state = res_pre_ok ? S_RES_ALIGN : S_IDLE;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_RES_ALIGN: n_state = S_RES_CHECK;
            S_RES_CHECK: n_state = S_IDLE;
            S_U_RD:      n_state = S_U_INIT;
            S_U_INIT:    n_state = S_WALK;
            S_WALK:      n_state = walk_more ? S_EX : (u_more ? S_U_RD : S_IDLE);
            S_EX:        n_state = ex_done ? S_STEP : S_EX;
            S_STEP:      n_state = S_WALK;
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        logic inv;
        inv = r_inval;
        n_ucnt = r_ucnt; n_mcnt = r_mcnt; n_ecnt = r_ecnt; n_modcnt = r_modcnt;
        n_kseen = r_kseen; n_mseen = r_mseen; n_inval = r_inval;
        n_cursor = r_cursor; n_end = r_end;
        n_i = r_i; n_j = r_j; n_rdv = r_rdv;
        n_item = r_item; n_cur = r_cur; n_largest = r_largest; n_a = r_a;
        n_wend = r_wend; n_next = r_next; n_cov = r_cov;
        n_st = r_st; n_addr = r_addr; n_gr = r_gr;
        n_out_valid = r_out_valid && !i_tready;
        u_we = 1'b0;
        e_we = 1'b0;
        o_q_pop = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (idle_go) begin
                    o_q_pop = 1'b1;
                    n_item  = i_q_item;
                    n_addr  = 32'd0;
                    n_gr    = 32'd0;
                    case (i_q_item.op)
                        OP_BEGIN: begin
                            n_ucnt = '0; n_mcnt = '0; n_ecnt = '0; n_modcnt = '0;
                            n_kseen = 1'b0; n_mseen = 1'b0; n_inval = 1'b0;
                            n_cursor = 32'd0; n_end = 32'd0;
                            n_st = ST_OK;
                            n_out_valid = 1'b1;
                        end
                        OP_LOAD: begin
                            case (i_q_item.kind)
                                KIND_USABLE, KIND_RESERVED: begin
                                    if (r_mcnt >= MAP_FULL || i_q_item.wrap) begin
                                        inv = 1'b1;
                                    end else begin
                                        n_mcnt = r_mcnt + 1'b1;
                                        if (i_q_item.kind == KIND_USABLE) begin
                                            u_we   = 1'b1;
                                            n_ucnt = r_ucnt + 1'b1;
                                        end else if (r_ecnt < EXCL_FULL) begin
                                            e_we   = 1'b1;
                                            n_ecnt = r_ecnt + 1'b1;
                                        end
                                    end
                                end
                                KIND_KERNEL, KIND_META: begin
                                    if (((i_q_item.kind == KIND_KERNEL) ? r_kseen : r_mseen)
                                        || i_q_item.len_zero || !i_q_item.fits) begin
                                        inv = 1'b1;
                                    end else begin
                                        if (i_q_item.kind == KIND_KERNEL) n_kseen = 1'b1;
                                        else                              n_mseen = 1'b1;
                                        if (r_ecnt < EXCL_FULL) begin
                                            e_we   = 1'b1;
                                            n_ecnt = r_ecnt + 1'b1;
                                        end
                                    end
                                end
                                KIND_MODULE: begin
                                    if (r_modcnt >= MOD_FULL || !i_q_item.fits) begin
                                        inv = 1'b1;
                                    end else begin
                                        n_modcnt = r_modcnt + 1'b1;
                                        if (r_ecnt < EXCL_FULL) begin
                                            e_we   = 1'b1;
                                            n_ecnt = r_ecnt + 1'b1;
                                        end
                                    end
                                end
                                default: inv = 1'b1;
                            endcase
                            n_inval = inv;
                            n_st = inv ? ST_INVALID : ST_OK;
                            n_out_valid = 1'b1;
                        end
                        OP_BUILD: begin
                            n_cursor  = 32'd0;
                            n_end     = 32'd0;
                            n_i       = '0;
                            n_largest = 33'd0;
                            if (!build_ok) begin
                                // A setup with no usable range simply finds no gap.
                                n_st = (!r_inval && (r_mcnt != '0) && r_kseen && r_mseen)
                                       ? ST_NO_GAP : ST_INVALID;
                                n_out_valid = 1'b1;
                            end
                        end
                        default: begin
                            if (!res_pre_ok) begin
                                n_st = ST_REFUSED;
                                n_out_valid = 1'b1;
                            end
                        end
                    endcase
                end
            end
            S_RES_ALIGN: n_a = a_calc;
            S_RES_CHECK: begin
                n_out_valid = 1'b1;
                if (res_bad) begin
                    n_st = ST_REFUSED;
                end else begin
                    n_st     = ST_OK;
                    n_addr   = r_a[31:0];
                    n_gr     = r_item.size;
                    n_cursor = r_a[31:0] + r_item.size;
                end
            end
            S_U_INIT: begin
                if (u_skip) begin
                    n_cur  = 33'd0;
                    n_wend = 32'd0;
                end else begin
                    n_cur  = ini_cur;
                    n_wend = endc;
                end
            end
            S_WALK: begin
                if (walk_more) begin
                    n_j   = '0;
                    n_rdv = 1'b0;
                    n_cov = cur64;
                    n_next = r_wend;
                end else if (u_more) begin
                    n_i = r_i + 1'b1;
                end else begin
                    n_st = (r_cursor == 32'd0) ? ST_NO_GAP : ST_OK;
                    n_out_valid = 1'b1;
                end
            end
            S_EX: begin
                // One excluded entry read per cycle; its data is folded in next cycle.
                if (r_j < r_ecnt) begin
                    n_j   = r_j + 1'b1;
                    n_rdv = 1'b1;
                end else begin
                    n_rdv = 1'b0;
                end
                if (r_rdv && (el != 64'd0)) begin
                    if ((eb <= cur64) && (ee > r_cov)) begin
                        n_cov = ee;
                    end else if ((eb > cur64) && (eb < {32'd0, r_next})) begin
                        n_next = eb[31:0];
                    end
                end
            end
            S_STEP: begin
                if (r_cov > cur64) begin
                    n_cur = (r_cov >= {32'd0, r_wend}) ? {1'b0, r_wend} : up_cov;
                end else begin
                    if (better) begin
                        n_cursor  = r_cur[31:0];
                        n_end     = gap[31:0];
                        n_largest = gap_len;
                    end
                    n_cur = {1'b0, r_next};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ucnt      <= '0;
            r_mcnt      <= '0;
            r_ecnt      <= '0;
            r_modcnt    <= '0;
            r_kseen     <= 1'b0;
            r_mseen     <= 1'b0;
            r_inval     <= 1'b0;
            r_cursor    <= 32'd0;
            r_end       <= 32'd0;
            r_i         <= '0;
            r_j         <= '0;
            r_rdv       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ucnt      <= n_ucnt;
            r_mcnt      <= n_mcnt;
            r_ecnt      <= n_ecnt;
            r_modcnt    <= n_modcnt;
            r_kseen     <= n_kseen;
            r_mseen     <= n_mseen;
            r_inval     <= n_inval;
            r_cursor    <= n_cursor;
            r_end       <= n_end;
            r_i         <= n_i;
            r_j         <= n_j;
            r_rdv       <= n_rdv;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item    <= n_item;
        r_cur     <= n_cur;
        r_largest <= n_largest;
        r_a       <= n_a;
        r_wend    <= n_wend;
        r_next    <= n_next;
        r_cov     <= n_cov;
        r_st      <= n_st;
        r_addr    <= n_addr;
        r_gr      <= n_gr;
    end

    always_ff @(posedge i_clk) begin
        if (u_we) u_mem[r_ucnt[UIW-1:0]] <= {i_q_item.length, i_q_item.base};
        r_u_rd <= u_mem[r_i[UIW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (e_we) e_mem[r_ecnt[EIW-1:0]] <= {i_q_item.length, i_q_item.base};
        r_e_rd <= e_mem[r_j[EIW-1:0]];
    end

    assign o_tvalid = r_out_valid;
    assign o_tuser  = r_st;
    assign o_tdata  = {r_end - r_cursor, r_gr, r_addr};
    assign o_stat.cursor   = r_cursor;
    assign o_stat.pool_end = r_end;
endmodule

@@ rtl/dma_pool_carve_and_bump_allocate.sv @@
// Top level of the DMA pool carve and bump allocator.
// A build walks each usable range, reading one excluded entry per cycle from its table memory.
// One request is executed at a time; two more wait in the request queue.
// Reset (synchronous, active low) empties the tables, the queue and the pool at once.
module dma_pool_carve_and_bump_allocate #(
    parameter int MAP_ENTRIES    = dpca_pkg::MAP_ENTRIES_DEF,
    parameter int MODULE_ENTRIES = dpca_pkg::MODULE_ENTRIES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // base [63:0], length [127:64], alloc_size [159:128], alignment [191:160]
    input  logic [191:0] i_s_axis_tdata,
    // op [1:0], kind [4:2]
    input  logic [4:0]   i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // address [31:0], granted_size [63:32], available [95:64]
    output logic [95:0]  o_m_axis_tdata,
    // status [1:0]
    output logic [1:0]   o_m_axis_tuser
);
    import dpca_pkg::*;

    // The front end classifies each request transfer (wrap, fit, power-of-two
    // checks) and pushes it into the queue whenever the queue has room.
    logic       q_push, q_full, q_pop, q_valid;
    t_item      f_item, q_item;
    t_back_stat stat;

    dpca_front u_front (
        .i_tvalid (i_s_axis_tvalid),
        .o_tready (o_s_axis_tready),
        .i_tdata  (i_s_axis_tdata),
        .i_tuser  (i_s_axis_tuser),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_item   (f_item)
    );

    dpca_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (f_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    // The back end owns the range tables and the pool; its result register
    // holds one result transfer until the sink takes it.
    dpca_back #(
        .MAP_ENTRIES    (MAP_ENTRIES),
        .MODULE_ENTRIES (MODULE_ENTRIES)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_pop   (q_pop),
        .o_tvalid  (o_m_axis_tvalid),
        .i_tready  (i_m_axis_tready),
        .o_tdata   (o_m_axis_tdata),
        .o_tuser   (o_m_axis_tuser),
        .o_stat    (stat)
    );

`ifndef ASSERT_OFF
    // The bump cursor never runs past the pool end.
    a_cursor_in_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.cursor <= stat.pool_end)
        else $error("bump cursor beyond pool end");

    // An empty pool has both bounds at zero.
    a_empty_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (stat.cursor == 32'd0) |-> (stat.pool_end == 32'd0))
        else $error("pool end set without a cursor");

    // A refused reserve never reports a grant.
    a_refuse_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser == ST_REFUSED)) |->
        (o_m_axis_tdata[63:0] == 64'd0))
        else $error("refused reserve carries a grant");
`endif
endmodule
